[hdl/gps_pkg.sv]
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, widths and the exponential table of the Gaussian population
// spike encoder.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int MAX_NEURONS     = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int INTENSITY_W = 16;
  localparam int NEURON_IDX_W = 4;
  localparam int TIME_W       = 16;
  localparam int CFG_DATA_W   = 17;
  localparam int CFG_IDX_W    = 3;

  localparam int POP_W   = 5;
  localparam int STEP_W  = 15;
  localparam int RATE_W  = 16;
  localparam int RESP_W  = 17;
  localparam int X_W     = 15;
  localparam logic [X_W-1:0] ONE_Q14 = X_W'(16384);

  localparam int NIDX_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int PREF_W = NIDX_W + STEP_W;
  localparam int SQ_W   = 2 * PREF_W;
  localparam int A_W    = SQ_W + RATE_W;
  localparam int A_FRAC = 40;
  localparam int P_W    = A_FRAC + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int KW     = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int FRAC_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POP_SIZE   = 3'd0,
    CFG_PREF_STEP  = 3'd1,
    CFG_TUNING     = 3'd2,
    CFG_MIN_RESP   = 3'd3,
    CFG_BASELINE   = 3'd4,
    CFG_SCALE      = 3'd5,
    CFG_WINDOW     = 3'd6
  } gps_cfg_idx_t;

  typedef struct packed {
    logic [POP_W-1:0]  neuron_count;
    logic [STEP_W-1:0] preferred_step;
    logic [RATE_W-1:0] tuning_rate;
    logic [RESP_W-1:0] fire_level;
    logic [TIME_W-1:0] baseline_time;
    logic [TIME_W-1:0] intensity_scale;
    logic [TIME_W-1:0] temporal_window;
  } gps_cfg_t;

  typedef struct packed {
    logic [NIDX_W-1:0] idx;
    logic [PREF_W-1:0] mag;
    logic              last;
  } gps_job_t;

  typedef struct packed {
    logic [NIDX_W-1:0] idx;
    logic              last;
  } gps_tag_t;

  typedef logic [EXP_TABLE_DEPTH:0][RESP_W-1:0] exp_tab_t;

  // exp(-16k/DEPTH) in Q1.16, from a Q1.31 product chain of a Taylor ratio
  function automatic exp_tab_t build_exp_tab();
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] v;
    exp_tab_t    t;
    x    = (64'd16 << 31) / EXP_TABLE_DEPTH;
    term = 64'd1 << 31;
    r    = term;
    v    = 64'd1 << 31;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * x) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      t[k] = RESP_W'((v + (64'd1 << 14)) >> 15);
      v    = (v * r) >> 31;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[hdl/gps_in_if.sv]
// ----------------------------------------------------------------------------
// gps_in_if
// Intensity channel: one signed Q1.14 feature value per beat.
// ----------------------------------------------------------------------------
interface gps_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gps_pkg::INTENSITY_W-1:0] intensity;

  modport source (output valid, output intensity, input ready);
  modport sink   (input valid, input intensity, output ready);
endinterface

[hdl/gps_out_if.sv]
// ----------------------------------------------------------------------------
// gps_out_if
// Spike channel: one neuron result per beat.
// ----------------------------------------------------------------------------
interface gps_out_if;
  logic                               valid;
  logic                               ready;
  logic [gps_pkg::NEURON_IDX_W-1:0]   neuron_index;
  logic                               spike_valid;
  logic [gps_pkg::TIME_W-1:0]         spike_time;
  logic                               last;

  modport source (output valid, output neuron_index, output spike_valid,
                  output spike_time, output last, input ready);
  modport sink   (input valid, input neuron_index, input spike_valid,
                  input spike_time, input last, output ready);
endinterface

[hdl/gps_front.sv]
// ----------------------------------------------------------------------------
// gps_front
// Accepts intensity beats, drops negative ones, clamps the rest and issues
// one job per neuron with its distance to the preferred value.
// ----------------------------------------------------------------------------
module gps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  gps_pkg::gps_cfg_t cfg,
  gps_in_if.sink            in_if,
  output logic              job_push,
  output gps_pkg::gps_job_t job,
  input  logic              job_full
);
  import gps_pkg::*;

  logic              busy_r, busy_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [PREF_W-1:0] pref_r, pref_nxt;
  logic [NIDX_W-1:0] idx_r, idx_nxt;
  logic [NIDX_W-1:0] last_idx_r, last_idx_nxt;
  logic              accept;
  logic              job_last;

  assign job_last    = (idx_r == last_idx_r);
  assign job_push    = busy_r && !job_full;
  assign in_if.ready = !busy_r || (job_push && job_last);
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    job.idx  = idx_r;
    job.last = job_last;
    if (pref_r > PREF_W'(x_r)) begin
      job.mag = pref_r - PREF_W'(x_r);
    end else begin
      job.mag = PREF_W'(x_r) - pref_r;
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    x_nxt        = x_r;
    pref_nxt     = pref_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    if (job_push) begin
      pref_nxt = pref_r + PREF_W'(cfg.preferred_step);
      idx_nxt  = idx_r + NIDX_W'(1);
      if (job_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = !in_if.intensity[INTENSITY_W-1];
      pref_nxt = '0;
      idx_nxt  = '0;
      if (in_if.intensity > $signed(INTENSITY_W'(ONE_Q14))) begin
        x_nxt = ONE_Q14;
      end else begin
        x_nxt = in_if.intensity[X_W-1:0];
      end
      if (cfg.neuron_count == '0) begin
        last_idx_nxt = '0;
      end else if (32'(cfg.neuron_count) >= MAX_NEURONS) begin
        last_idx_nxt = NIDX_W'(MAX_NEURONS - 1);
      end else begin
        last_idx_nxt = NIDX_W'(cfg.neuron_count - POP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r        <= x_nxt;
    pref_r     <= pref_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
  end

endmodule

[hdl/gps_queue.sv]
// ----------------------------------------------------------------------------
// gps_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module gps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gps_pkg::gps_job_t wr_job,
  output logic              full,
  input  logic              pop,
  output gps_pkg::gps_job_t rd_job,
  output logic              not_empty
);
  import gps_pkg::*;

  gps_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_job    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[hdl/gps_back.sv]
// ----------------------------------------------------------------------------
// gps_back
// Per-neuron pipeline: square, exponent, table lookup, interpolation,
// latency, threshold and window, then the output register.
// ----------------------------------------------------------------------------
module gps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  gps_pkg::gps_cfg_t cfg,
  input  gps_pkg::gps_job_t job,
  input  logic              job_avail,
  output logic              job_pop,
  gps_out_if.source         out_if
);
  import gps_pkg::*;

  logic advance;

  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  gps_tag_t          t1_r, t2_r, t3_r, t4_r, t5_r;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [A_W-1:0]    a_r, a_nxt;
  logic              zero_r, zero_nxt;
  logic [RESP_W-1:0] hi_r, hi_nxt;
  logic [RESP_W-1:0] dlt_r, dlt_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [RESP_W-1:0] resp_r, resp_nxt;
  logic              fire_r, fire_nxt;
  logic [TIME_W-1:0] lat_r, lat_nxt;

  logic              out_valid_r;
  gps_tag_t          out_tag_r;
  logic              out_sv_r, out_sv_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;

  logic [P_W-1:0]           p;
  logic [KW-1:0]            k;
  logic [RESP_W-1:0]        lo;
  logic [RESP_W+FRAC_W:0]   corr;
  logic [RESP_W+TIME_W:0]   lat_full;
  logic [TIME_W:0]          when;

  assign advance = !out_valid_r || out_if.ready;
  assign job_pop = advance && job_avail;

  always_comb begin
    sq_nxt = SQ_W'(job.mag) * SQ_W'(job.mag);
    a_nxt  = A_W'(sq_r) * A_W'(cfg.tuning_rate);

    zero_nxt = (a_r >= (A_W'(1) << A_FRAC));
    p        = P_W'(a_r[A_FRAC-1:0]) * P_W'(EXP_TABLE_DEPTH);
    k        = KW'(p >> A_FRAC);
    frac_nxt = p[A_FRAC-1 -: FRAC_W];
    hi_nxt   = EXP_TAB[k];
    lo       = EXP_TAB[k + KW'(1)];
    dlt_nxt  = hi_nxt - lo;

    corr = ((RESP_W+FRAC_W+1)'(dlt_r) * (RESP_W+FRAC_W+1)'(frac_r)
            + (RESP_W+FRAC_W+1)'(32768)) >> 16;
    if (zero_r) begin
      resp_nxt = '0;
    end else begin
      resp_nxt = hi_r - RESP_W'(corr);
    end

    fire_nxt = (resp_r >= cfg.fire_level);
    lat_full = ((RESP_W+TIME_W+1)'(RESP_W'(65536) - resp_r)
                * (RESP_W+TIME_W+1)'(cfg.intensity_scale)
                + (RESP_W+TIME_W+1)'(32768)) >> 16;
    lat_nxt  = TIME_W'(lat_full);

    when = (TIME_W+1)'(cfg.baseline_time) + (TIME_W+1)'(lat_r);
    if (fire_r && (when <= (TIME_W+1)'(cfg.temporal_window))) begin
      out_sv_nxt   = 1'b1;
      out_time_nxt = when[TIME_W-1:0];
    end else begin
      out_sv_nxt   = 1'b0;
      out_time_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= job_avail;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
    if (advance) begin
      t1_r       <= '{idx: job.idx, last: job.last};
      t2_r       <= t1_r;
      t3_r       <= t2_r;
      t4_r       <= t3_r;
      t5_r       <= t4_r;
      out_tag_r  <= t5_r;
      sq_r       <= sq_nxt;
      a_r        <= a_nxt;
      zero_r     <= zero_nxt;
      hi_r       <= hi_nxt;
      dlt_r      <= dlt_nxt;
      frac_r     <= frac_nxt;
      resp_r     <= resp_nxt;
      fire_r     <= fire_nxt;
      lat_r      <= lat_nxt;
      out_sv_r   <= out_sv_nxt;
      out_time_r <= out_time_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.neuron_index = NEURON_IDX_W'(out_tag_r.idx);
  assign out_if.spike_valid  = out_sv_r;
  assign out_if.spike_time   = out_time_r;
  assign out_if.last         = out_tag_r.last;

endmodule

[hdl/gaussian_population_spike_encoder.sv]
// ----------------------------------------------------------------------------
// gaussian_population_spike_encoder
// Gaussian population latency encoder: one intensity beat in, one spike
// result beat per population neuron out.
//
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    intensity
//   out_if   out  valid/ready    neuron_index, spike_valid, spike_time, last
//   cfg_     in   cfg_we         cfg_index, cfg_wdata
//
// The front issues one neuron per cycle while the queue is not full; a
// negative intensity is accepted and yields nothing.
// The back pipeline runs six stages from queue to output register, one
// result per cycle when the output is not stalled. Reset is synchronous;
// config returns to defaults. A stalled output freezes the whole back
// pipeline; the four-entry queue lets the front keep issuing until it fills.
// ----------------------------------------------------------------------------
module gaussian_population_spike_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  gps_in_if.sink                           in_if,
  gps_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [gps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gps_pkg::*;

  gps_cfg_t cfg_r, cfg_nxt;
  logic     job_push;
  logic     job_full;
  logic     job_pop;
  logic     job_avail;
  gps_job_t wr_job;
  gps_job_t rd_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (gps_cfg_idx_t'(cfg_index))
        CFG_POP_SIZE:  cfg_nxt.neuron_count    = cfg_wdata[POP_W-1:0];
        CFG_PREF_STEP: cfg_nxt.preferred_step  = cfg_wdata[STEP_W-1:0];
        CFG_TUNING:    cfg_nxt.tuning_rate     = cfg_wdata[RATE_W-1:0];
        CFG_MIN_RESP:  cfg_nxt.fire_level      = cfg_wdata[RESP_W-1:0];
        CFG_BASELINE:  cfg_nxt.baseline_time   = cfg_wdata[TIME_W-1:0];
        CFG_SCALE:     cfg_nxt.intensity_scale = cfg_wdata[TIME_W-1:0];
        CFG_WINDOW:    cfg_nxt.temporal_window = cfg_wdata[TIME_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neuron_count    <= POP_W'(5);
      cfg_r.preferred_step  <= STEP_W'(4096);
      cfg_r.tuning_rate     <= RATE_W'(1422);
      cfg_r.fire_level      <= RESP_W'(6554);
      cfg_r.baseline_time   <= TIME_W'(0);
      cfg_r.intensity_scale <= TIME_W'(2560);
      cfg_r.temporal_window <= TIME_W'(12800);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_if    (in_if),
    .job_push (job_push),
    .job      (wr_job),
    .job_full (job_full)
  );

  gps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .wr_job    (wr_job),
    .full      (job_full),
    .pop       (job_pop),
    .rd_job    (rd_job),
    .not_empty (job_avail)
  );

  gps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (rd_job),
    .job_avail (job_avail),
    .job_pop   (job_pop),
    .out_if    (out_if)
  );

endmodule
